// ===== hdl/dpbb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpbb_pkg
// Shared constants, types and helpers for the dark pixel bounding box unit.
// ----------------------------------------------------------------------------
package dpbb_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM);   // row / column index width
  localparam int CFG_W   = 13;                // widest register
  localparam int IDX_W   = 2;
  localparam int PIX_W   = 8;

  localparam logic [IDX_W-1:0] REG_DARK_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd2;

  localparam logic [PIX_W-1:0] DARK_THRESHOLD_RESET = 8'd200;
  localparam logic [CFG_W-1:0] DIM_RESET            = 13'd1024;

  typedef struct packed {
    logic [PIX_W-1:0] threshold;
    logic [DIM_W-1:0] last_col;
    logic [DIM_W-1:0] last_row;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [DIM_W-1:0] left_col;
    logic [DIM_W-1:0] top_row;
    logic [DIM_W-1:0] crop_width;
    logic [DIM_W-1:0] crop_height;
  } rect_t;

  // Last index of a dimension clamped to [2, MAX_DIM].
  function automatic logic [DIM_W-1:0] last_index(input logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (d < CFG_W'(2)) begin
      res = DIM_W'(1);
    end else if (d > CFG_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM - 1);
    end else begin
      res = DIM_W'(d - CFG_W'(1));
    end
    return res;
  endfunction

endpackage

// ===== hdl/dpbb_extent.sv =====
// ----------------------------------------------------------------------------
// dpbb_extent
// Raster counters and dark pixel extent trackers; forms the crop rectangle.
// ----------------------------------------------------------------------------
module dpbb_extent (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [dpbb_pkg::PIX_W-1:0] pixel,
  input  dpbb_pkg::cfg_t             cfg,
  output logic                       frame_end,
  output dpbb_pkg::rect_t            rect
);
  import dpbb_pkg::*;

  logic [DIM_W-1:0] col_r, row_r;
  logic             any_r;
  logic [DIM_W-1:0] minr_r, maxr_r, minc_r, maxc_r;

  logic             dark, row_end;
  logic             any_upd;
  logic [DIM_W-1:0] minr_upd, maxr_upd, minc_upd, maxc_upd;
  logic [DIM_W:0]   maxc_p1;
  logic [DIM_W-1:0] left, right;

  assign dark     = pixel < cfg.threshold;
  assign any_upd  = any_r | dark;
  assign minr_upd = (dark && row_r < minr_r) ? row_r : minr_r;
  assign maxr_upd = (dark && row_r > maxr_r) ? row_r : maxr_r;
  assign minc_upd = (dark && col_r < minc_r) ? col_r : minc_r;
  assign maxc_upd = (dark && col_r > maxc_r) ? col_r : maxc_r;

  assign row_end   = col_r >= cfg.last_col;
  assign frame_end = row_end && (row_r >= cfg.last_row);

  assign maxc_p1 = {1'b0, maxc_upd} + (DIM_W+1)'(1);
  assign left    = (minc_upd == '0) ? '0 : minc_upd - DIM_W'(1);
  assign right   = (maxc_p1 > {1'b0, cfg.last_col}) ? cfg.last_col : maxc_p1[DIM_W-1:0];

  always_comb begin
    rect = '0;
    if (any_upd && maxr_upd != '0 && maxc_upd != '0) begin
      rect.found       = 1'b1;
      rect.left_col    = left;
      rect.top_row     = minr_upd;
      rect.crop_width  = right - left;
      rect.crop_height = maxr_upd - minr_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      any_r  <= 1'b0;
      minr_r <= '1;
      maxr_r <= '0;
      minc_r <= '1;
      maxc_r <= '0;
    end else if (step) begin
      if (frame_end) begin
        col_r  <= '0;
        row_r  <= '0;
        any_r  <= 1'b0;
        minr_r <= '1;
        maxr_r <= '0;
        minc_r <= '1;
        maxc_r <= '0;
      end else begin
        any_r  <= any_upd;
        minr_r <= minr_upd;
        maxr_r <= maxr_upd;
        minc_r <= minc_upd;
        maxc_r <= maxc_upd;
        if (row_end) begin
          col_r <= '0;
          row_r <= row_r + DIM_W'(1);
        end else begin
          col_r <= col_r + DIM_W'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/dark_pixel_bounding_box_unit.sv =====
// ----------------------------------------------------------------------------
// dark_pixel_bounding_box_unit
// Finds the crop rectangle around the dark pixels of a raster-order frame.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   in_      | input     | in_valid / in_stall  | pixel_value
//   out_     | output    | out_valid / out_stall| found, left_col, top_row,
//            |           |                      | crop_width, crop_height
//   cfg_     | input     | cfg_wr_en            | cfg_index, cfg_data
//
// One pixel word is taken every cycle while in_stall is low. A word waits in the input
// register and updates the counters and trackers when it advances; the last
// pixel of a frame loads the result register as it advances. Reset clears all frame
// state and loads the register defaults (threshold 200, 1024 x 1024). in_stall
// rises only when the frame's last pixel waits behind an undelivered result
// that out_stall holds.
//
module dark_pixel_bounding_box_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dpbb_pkg::PIX_W-1:0] in_pixel_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic [dpbb_pkg::DIM_W-1:0] out_left_col,
  output logic [dpbb_pkg::DIM_W-1:0] out_top_row,
  output logic [dpbb_pkg::DIM_W-1:0] out_crop_width,
  output logic [dpbb_pkg::DIM_W-1:0] out_crop_height,
  input  logic                       cfg_wr_en,
  input  logic [dpbb_pkg::IDX_W-1:0] cfg_index,
  input  logic [dpbb_pkg::CFG_W-1:0] cfg_data
);
  import dpbb_pkg::*;

  // Configuration registers
  logic [PIX_W-1:0] threshold_r;
  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  cfg_t             cfg;

  // Input register
  logic             pix_valid_r;
  logic [PIX_W-1:0] pix_r;

  // Result register
  logic             out_valid_r;
  rect_t            rect_r;

  logic  frame_end, fire, in_accept, out_free;
  rect_t rect;

  // Plain write port; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= DARK_THRESHOLD_RESET;
      frame_width_r  <= DIM_RESET;
      frame_height_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DARK_THRESHOLD: threshold_r    <= cfg_data[PIX_W-1:0];
        REG_FRAME_WIDTH:    frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT:   frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.threshold = threshold_r;
  assign cfg.last_col  = last_index(frame_width_r);
  assign cfg.last_row  = last_index(frame_height_r);

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Advance the held pixel unless it closes a frame and the result slot is busy.
  assign fire      = pix_valid_r && (!frame_end || out_free);
  assign in_stall  = pix_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_accept) begin
      pix_valid_r <= 1'b1;
    end else if (fire) begin
      pix_valid_r <= 1'b0;
    end
  end

  // Hold the pixel word while stalled.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pix_r <= in_pixel_value;
    end
  end

  dpbb_extent u_extent (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .pixel     (pix_r),
    .cfg       (cfg),
    .frame_end (frame_end),
    .rect      (rect)
  );

  // Load a result on the last pixel; drop the valid once the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && frame_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && frame_end) begin
      rect_r <= rect;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = rect_r.found;
  assign out_left_col    = rect_r.left_col;
  assign out_top_row     = rect_r.top_row;
  assign out_crop_width  = rect_r.crop_width;
  assign out_crop_height = rect_r.crop_height;

endmodule

// ===== hdl/dpbb_checker.sv =====
// ----------------------------------------------------------------------------
// dpbb_checker
// Port-level assertions for the dark pixel bounding box unit.
// ----------------------------------------------------------------------------
module dpbb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [dpbb_pkg::PIX_W-1:0] in_pixel_value,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_found,
  input logic [dpbb_pkg::DIM_W-1:0] out_left_col,
  input logic [dpbb_pkg::DIM_W-1:0] out_top_row,
  input logic [dpbb_pkg::DIM_W-1:0] out_crop_width,
  input logic [dpbb_pkg::DIM_W-1:0] out_crop_height,
  input logic                       cfg_wr_en,
  input logic [dpbb_pkg::IDX_W-1:0] cfg_index,
  input logic [dpbb_pkg::CFG_W-1:0] cfg_data
);
  import dpbb_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_left_col)
      && $stable(out_top_row) && $stable(out_crop_width) && $stable(out_crop_height))
    else $error("stalled result word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result word");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_left_col == '0 && out_top_row == '0
      && out_crop_width == '0 && out_crop_height == '0)
    else $error("empty rectangle carries nonzero fields");

endmodule

bind dark_pixel_bounding_box_unit dpbb_checker u_dpbb_checker (.*);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dark pixel bounding box unit. Pixel words stream
// in raster order under random bursts, gaps and output stalls. A scoreboard
// class tracks the dark extent of each frame and predicts every crop rectangle.
// ----------------------------------------------------------------------------
module tb;
  import dpbb_pkg::*;

  // Index that maps to no register; the block must ignore writes to it.
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SMALL_WORDS = 1700;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the frame the block is working on and queues the crop
  // rectangle that each frame's last pixel word should produce.
  // --------------------------------------------------------------------------
  class crop_scoreboard;
    logic [PIX_W-1:0] threshold;
    logic [CFG_W-1:0] width_word;
    logic [CFG_W-1:0] height_word;
    int unsigned col_at;
    int unsigned row_at;
    bit          dark_any;
    int unsigned dark_top;
    int unsigned dark_bottom;
    int unsigned dark_left;
    int unsigned dark_right;
    rect_t       crops_due[$];
    int unsigned mismatches;

    function new();
      threshold   = DARK_THRESHOLD_RESET;
      width_word  = DIM_RESET;
      height_word = DIM_RESET;
      mismatches  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      col_at      = 0;
      row_at      = 0;
      dark_any    = 1'b0;
      dark_top    = 32'hFFFF_FFFF;
      dark_bottom = 0;
      dark_left   = 32'hFFFF_FFFF;
      dark_right  = 0;
    endfunction

    // Out-of-range sizes saturate to the supported span.
    function int unsigned usable_dim(logic [CFG_W-1:0] word);
      if (word < 2) return 2;
      if (word > MAX_DIM) return MAX_DIM;
      return word;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] word);
      case (idx)
        REG_DARK_THRESHOLD: threshold   = word[PIX_W-1:0];
        REG_FRAME_WIDTH:    width_word  = word;
        REG_FRAME_HEIGHT:   height_word = word;
        default: ;
      endcase
    endfunction

    // Advance the frame by one accepted pixel word.
    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned left;
      int unsigned right;
      bit          row_end;
      bit          frame_end;
      rect_t       crop;
      w = usable_dim(width_word);
      h = usable_dim(height_word);
      if (pix < threshold) begin
        dark_any = 1'b1;
        if (row_at < dark_top)    dark_top    = row_at;
        if (row_at > dark_bottom) dark_bottom = row_at;
        if (col_at < dark_left)   dark_left   = col_at;
        if (col_at > dark_right)  dark_right  = col_at;
      end
      // A counter left past a shrunken size counts as sitting on the last index.
      row_end   = col_at >= w - 1;
      frame_end = row_end && (row_at >= h - 1);
      if (!frame_end) begin
        if (row_end) begin
          col_at = 0;
          row_at++;
        end else begin
          col_at++;
        end
        return;
      end
      crop = '0;
      // Dark pixels confined to row 0 or to column 0 give no rectangle.
      if (dark_any && dark_bottom >= 1 && dark_right >= 1) begin
        left  = (dark_left == 0) ? 0 : dark_left - 1;
        right = (dark_right + 1 > w - 1) ? w - 1 : dark_right + 1;
        crop.found       = 1'b1;
        crop.left_col    = DIM_W'(left);
        crop.top_row     = DIM_W'(dark_top);
        crop.crop_width  = DIM_W'(right - left);
        crop.crop_height = DIM_W'(dark_bottom - dark_top);
      end
      crops_due.insert(crops_due.size(), crop);
      clear_frame();
    endfunction

    function void complain(string what, rect_t want, rect_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("crop error (%s): expected found=%0d left=%0d top=%0d w=%0d h=%0d",
                 what, want.found, want.left_col, want.top_row, want.crop_width,
                 want.crop_height);
        $display("  got found=%0d left=%0d top=%0d w=%0d h=%0d",
                 got.found, got.left_col, got.top_row, got.crop_width,
                 got.crop_height);
      end
    endfunction

    function void check_rect(rect_t got);
      rect_t want;
      if (crops_due.size() == 0) begin
        complain("no frame pending", '0, got);
        return;
      end
      want = crops_due.pop_front();
      if (got.found !== want.found || got.left_col !== want.left_col ||
          got.top_row !== want.top_row || got.crop_width !== want.crop_width ||
          got.crop_height !== want.crop_height)
        complain("field mismatch", want, got);
    endfunction

    function bit clean();
      return mismatches == 0 && crops_due.size() == 0;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block signals; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_pixel_value = '0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  logic             out_found;
  logic [DIM_W-1:0] out_left_col;
  logic [DIM_W-1:0] out_top_row;
  logic [DIM_W-1:0] out_crop_width;
  logic [DIM_W-1:0] out_crop_height;
  logic             cfg_wr_en      = 1'b0;
  logic [IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0] cfg_data       = '0;

  crop_scoreboard board;
  int             cycle_count = 0;
  int             burst_left  = 0;
  int             gap_max     = 8;
  int             stall_tick  = 0;
  stall_mode_t    stall_mode  = STALL_NONE;

  dark_pixel_bounding_box_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_left_col    (out_left_col),
    .out_top_row     (out_top_row),
    .out_crop_width  (out_crop_width),
    .out_crop_height (out_crop_height),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stall on a pattern whose style is redrawn at random, so
  // results meet open stretches, random stalls, periodic stalls and long holds.
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
      default:        out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check every result word at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_rect({out_found, out_left_col, out_top_row, out_crop_width,
                        out_crop_height});
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task starts and ends at a falling edge.
  // --------------------------------------------------------------------------

  // Send one pixel word; open a fresh burst, with a random gap ahead of it,
  // whenever the current one runs out. Hold the word until the block takes it.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pixel(pix);
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending rectangle, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.crops_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] word);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    board.write_reg(idx, word);
    @(negedge clk);
  endtask

  task automatic configure(input bit with_thr, input logic [CFG_W-1:0] thr_word,
                           input logic [CFG_W-1:0] w_word, input logic [CFG_W-1:0] h_word);
    if (with_thr) write_reg(REG_DARK_THRESHOLD, thr_word);
    write_reg(REG_FRAME_WIDTH, w_word);
    write_reg(REG_FRAME_HEIGHT, h_word);
    cfg_wr_en <= 1'b0;
  endtask

  // Dark values are drawn below the current threshold, light ones at or
  // above it; with a threshold of 0 nothing can be dark.
  function automatic logic [PIX_W-1:0] pick_pixel(bit dark);
    int unsigned thr;
    thr = board.threshold;
    if (dark && thr != 0) return PIX_W'($urandom_range(0, thr - 1));
    return PIX_W'($urandom_range(thr, 255));
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return CFG_W'($urandom_range(0, 1));
      1:       return CFG_W'($urandom_range(9, 24));
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [PIX_W-1:0] seq[$];
    logic [CFG_W-1:0] thr_word;
    logic [CFG_W-1:0] w_word;
    logic [CFG_W-1:0] h_word;
    int phase_no;
    int small_sent;
    int frames;
    int n;
    int extra;
    int count;
    int dark_pct;

    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset threshold (200) kept; sizes 0 and 1 both saturate to 2.
    // Frames: dark at the bottom-right corner with 199/200 on the boundary,
    // then dark only in row 0, then dark only in column 0 (neither is found).
    configure(1'b0, '0, 13'd0, 13'd1);
    seq = '{8'd255, 8'd255, 8'd255, 8'd199,
            8'd200, 8'd0,   8'd255, 8'd255,
            8'd255, 8'd255, 8'd0,   8'd200};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();

    // Ignored index, then threshold 255 carried in a word with every bit set:
    // 254 is dark, 255 is not. Corner darks span the whole 3 x 2 frame.
    write_reg(REG_UNUSED, '1);
    configure(1'b1, 13'h1FFF, 13'd3, 13'd2);
    seq = '{8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();

    // Threshold 0: even all-zero pixels are not dark.
    configure(1'b1, 13'h1F00, 13'd2, 13'd2);
    seq = '{8'd0, 8'd0, 8'd0, 8'd0};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();

    // Random phases: small frames with random content, sometimes ending in a
    // partial frame that the next phase's sizes then cut short or stretch.
    // Phases 3 and 6 open an oversized wide or tall frame and leave it partial,
    // so the next phase's small sizes end it from past the last index.
    phase_no   = 0;
    small_sent = 0;
    while (small_sent < SMALL_WORDS || phase_no < 6) begin
      phase_no++;
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if (phase_no == 3 || phase_no == 6) begin
        if (phase_no == 3) configure(1'b1, 13'd128, 13'h1FFF, 13'd1);
        else               configure(1'b1, 13'd128, 13'd2, 13'd4096);
        count = $urandom_range(100, 200);
        for (int i = 0; i < count; i++)
          send_pixel(pick_pixel($urandom_range(0, 49) == 0));
        small_sent += count;
      end else begin
        thr_word = CFG_W'($urandom);
        case ($urandom_range(0, 9))
          0:       thr_word[PIX_W-1:0] = 8'd0;
          1:       thr_word[PIX_W-1:0] = 8'd255;
          default: ;
        endcase
        w_word = pick_dim();
        h_word = pick_dim();
        configure(1'b1, thr_word, w_word, h_word);
        n = (w_word < 2 ? 2 : w_word) * (h_word < 2 ? 2 : h_word);
        frames = $urandom_range(1, 4);
        // No partial frame right before an oversized-frame phase.
        extra = (phase_no != 2 && phase_no != 5 && $urandom_range(0, 2) == 0) ?
                $urandom_range(1, n - 1) : 0;
        for (int f = 0; f <= frames; f++) begin
          count = (f == frames) ? extra : n;
          case ($urandom_range(0, 4))
            0:       dark_pct = 0;
            1:       dark_pct = 3;
            2:       dark_pct = 20;
            3:       dark_pct = 60;
            default: dark_pct = 100;
          endcase
          repeat (count)
            send_pixel(($urandom_range(0, 7) == 0) ? PIX_W'($urandom) :
                       pick_pixel($urandom_range(0, 99) < dark_pct));
        end
        small_sent += frames * n + extra;
      end
      drain();
    end

    repeat (4) @(negedge clk);
    if (board.clean()) begin
      $display("*** PASSED ***");
    end else begin
      if (board.crops_due.size() != 0)
        $display("%0d crop results never arrived", board.crops_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dpbb_pkg.sv
hdl/dpbb_extent.sv
hdl/dark_pixel_bounding_box_unit.sv
hdl/dpbb_checker.sv
verif/tb.sv
